[hw/rtl/skf_pkg.sv]
package skf_pkg;

    localparam logic [16:0] VAR_FLOOR  = 17'd7;
    localparam logic [16:0] CONF_FLOOR = 17'd6554;
    localparam logic [16:0] DT_FLOOR   = 17'd66;
    localparam logic [15:0] EPS_Q32    = 16'd4295;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    localparam logic [31:0] P00_RESET  = 32'd65536;
    localparam logic [31:0] P11_RESET  = 32'd32768;
    localparam logic [16:0] Q_RESET    = 17'd655;
    localparam logic [16:0] R_RESET    = 17'd6554;
    localparam logic [16:0] DT_RESET   = 17'd6554;

    // register indexes on the configuration port
    localparam logic [1:0] REG_Q  = 2'd0;
    localparam logic [1:0] REG_R  = 2'd1;
    localparam logic [1:0] REG_DT = 2'd2;

    // iteration counts, minus one
    localparam logic [5:0] RDIV_LAST = 6'd32;
    localparam logic [5:0] GDIV_LAST = 6'd15;
    localparam logic [5:0] SQRT_LAST = 6'd23;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_PRED,
        S_RDIV,
        S_GINIT,
        S_GDIV,
        S_MUL3,
        S_UPD,
        S_SQRT,
        S_DONE
    } skf_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_PRED,
        OP_DIV_STEP,
        OP_GINIT,
        OP_MUL3,
        OP_UPD,
        OP_SQRT_STEP,
        OP_OUT
    } skf_op_t;

endpackage

[hw/rtl/skf_in_if.sv]
interface skf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_altitude;
    logic        [16:0] measured_confidence;

    modport source (output valid, output measured_altitude, output measured_confidence,
                    input ready);
    modport sink   (input valid, input measured_altitude, input measured_confidence,
                    output ready);
endinterface

[hw/rtl/skf_out_if.sv]
interface skf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_altitude;
    logic        [16:0] est_confidence;
    logic        [16:0] gain;
    logic signed [31:0] innovation;

    modport source (output valid, output est_altitude, output est_confidence,
                    output gain, output innovation, input ready);
    modport sink   (input valid, input est_altitude, input est_confidence,
                    input gain, input innovation, output ready);
endinterface

[hw/rtl/scalar_altitude_kalman_filter.sv]
// A new measurement is taken only in the idle state; the sequence waits in its last state
// while the output register is full. The shared one-bit-per-cycle divider (33 steps for
// the noise quotient, 16 for the gain) and the 24-step square root set the pace.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, asynchronous): estimate 0, variances 1.0 and 0.5, registers to defaults.
module scalar_altitude_kalman_filter
    import skf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    skf_in_if.sink      meas_in,
    skf_out_if.source   est_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [16:0] q_reg, r_reg, dt_reg;
    logic        cfg_write;
    logic [1:0]  cfg_idx;
    skf_op_t     op;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers: write on the access phase, drop unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= Q_RESET;
            r_reg  <= R_RESET;
            dt_reg <= DT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_Q:   q_reg  <= pwdata[16:0];
                REG_R:   r_reg  <= pwdata[16:0];
                REG_DT:  dt_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_Q:   prdata = {15'b0, q_reg};
            REG_R:   prdata = {15'b0, r_reg};
            REG_DT:  prdata = {15'b0, dt_reg};
            default: prdata = '0;
        endcase
    end

    // Sequencer: one step of the filter per state, iterating units counted down.
    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (meas_in.valid),
        .in_ready  (meas_in.ready),
        .out_valid (est_out.valid),
        .out_ready (est_out.ready),
        .op        (op)
    );

    // Datapath: prediction multipliers, shared divider, root unit, filter state.
    skf_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .q_noise             (q_reg),
        .r_noise             (r_reg),
        .time_step           (dt_reg),
        .measured_altitude   (meas_in.measured_altitude),
        .measured_confidence (meas_in.measured_confidence),
        .est_altitude        (est_out.est_altitude),
        .est_confidence      (est_out.est_confidence),
        .gain                (est_out.gain),
        .innovation          (est_out.innovation)
    );

endmodule

[hw/rtl/skf_ctrl.sv]
module skf_ctrl
    import skf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output skf_op_t op
);

    skf_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                op         = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                op         = OP_MUL2;
                state_next = S_PRED;
            end
            S_PRED:
            begin
                op         = OP_PRED;
                cnt_next   = RDIV_LAST;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_GINIT;
                end
            end
            S_GINIT:
            begin
                op         = OP_GINIT;
                cnt_next   = GDIV_LAST;
                state_next = S_GDIV;
            end
            S_GDIV:
            begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL3;
                end
            end
            S_MUL3:
            begin
                op         = OP_MUL3;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                op         = OP_UPD;
                cnt_next   = SQRT_LAST;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op       = OP_SQRT_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL1))
        else $error("accepted item did not start the sequence");
    a_gdiv_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GDIV) |-> (cnt_reg <= GDIV_LAST))
        else $error("gain division count out of range");
    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (cnt_reg <= SQRT_LAST))
        else $error("root count out of range");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_OUT) |=> (out_valid && state_reg == S_IDLE))
        else $error("result not presented after load");
`endif

endmodule

[hw/rtl/skf_dp.sv]
module skf_dp
    import skf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  skf_op_t            op,
    input  logic        [16:0] q_noise,
    input  logic        [16:0] r_noise,
    input  logic        [16:0] time_step,
    input  logic signed [31:0] measured_altitude,
    input  logic        [16:0] measured_confidence,
    output logic signed [31:0] est_altitude,
    output logic        [16:0] est_confidence,
    output logic        [16:0] gain,
    output logic signed [31:0] innovation
);

    logic signed [31:0] est_reg;
    logic        [31:0] p00_reg, p11_reg;

    logic signed [31:0] meas_reg;
    logic        [16:0] conf_reg;
    logic        [48:0] mula_reg;
    logic        [49:0] mulb_reg;
    logic signed [31:0] innov_reg;
    logic signed [48:0] kprod_reg;
    logic        [48:0] vprod_reg;

    logic [50:0] rem_reg;
    logic [32:0] dvd_reg;
    logic [49:0] dvs_reg;
    logic [32:0] quot_reg;

    logic [47:0] rad_reg;
    logic [25:0] srem_reg;
    logic [23:0] root_reg;

    logic signed [31:0] fa_reg, in_reg;
    logic        [16:0] ac_reg, k_reg;

    logic        [16:0] dt_eff;
    logic        [34:0] p00_sum;
    logic        [32:0] p11_sum;
    logic        [31:0] p00_pred, p11_pred;
    logic        [50:0] trial;
    logic               ge;
    logic        [33:0] pr_sum;
    logic        [49:0] den;
    logic signed [32:0] diff;
    logic signed [31:0] innov_sat;
    logic signed [48:0] kround;
    logic signed [32:0] delta;
    logic signed [33:0] est_sum;
    logic signed [31:0] est_sat;
    logic        [26:0] strial;
    logic        [26:0] stest;
    logic               sge;
    logic        [16:0] aconf;

    always_comb
    begin
        dt_eff   = (time_step < DT_FLOOR) ? DT_FLOOR : time_step;
        p00_sum  = {3'b0, p00_reg} + {1'b0, mulb_reg[49:16]} + {18'b0, q_noise};
        p11_sum  = {1'b0, p11_reg} + {16'b0, q_noise};
        p00_pred = (p00_sum > 35'hFFFFFFFF) ? 32'hFFFFFFFF : p00_sum[31:0];
        p11_pred = (p11_sum > 33'hFFFFFFFF) ? 32'hFFFFFFFF : p11_sum[31:0];
        if (p00_pred < {15'b0, VAR_FLOOR}) p00_pred = {15'b0, VAR_FLOOR};
        if (p11_pred < {15'b0, VAR_FLOOR}) p11_pred = {15'b0, VAR_FLOOR};

        trial = {rem_reg[49:0], dvd_reg[32]};
        ge    = (trial >= {1'b0, dvs_reg});

        pr_sum = {2'b0, p00_reg} + {1'b0, quot_reg};
        den    = {pr_sum, 16'b0} + {34'b0, EPS_Q32};

        diff = 33'(meas_reg) - 33'(est_reg);
        if (diff > 33'sh07FFFFFFF)
            innov_sat = 32'sh7FFFFFFF;
        else if (diff < -33'sh080000000)
            innov_sat = 32'sh80000000;
        else
            innov_sat = diff[31:0];

        // round half up, then floor through the arithmetic shift
        kround  = kprod_reg + 49'sd32768;
        delta   = kround[48:16];
        est_sum = 34'(est_reg) + 34'(delta);
        if (est_sum > 34'sh07FFFFFFF)
            est_sat = 32'sh7FFFFFFF;
        else if (est_sum < -34'sh080000000)
            est_sat = 32'sh80000000;
        else
            est_sat = est_sum[31:0];

        strial = {srem_reg[24:0], rad_reg[47:46]};
        stest  = {1'b0, root_reg, 2'b01};
        sge    = (strial >= stest);

        aconf = (root_reg[23:16] != '0) ? 17'd0 : (ONE_Q16 - {1'b0, root_reg[15:0]});
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            p00_reg <= P00_RESET;
            p11_reg <= P11_RESET;
        end
        else
        begin
            if (op == OP_PRED)
            begin
                p00_reg <= p00_pred;
                p11_reg <= p11_pred;
            end
            if (op == OP_UPD)
            begin
                est_reg <= est_sat;
                p00_reg <= vprod_reg[47:16];
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                meas_reg <= measured_altitude;
                conf_reg <= (measured_confidence < CONF_FLOOR) ? CONF_FLOOR
                                                               : measured_confidence;
            end
            OP_MUL1:
            begin
                mula_reg <= p11_reg * dt_eff;
            end
            OP_MUL2:
            begin
                mulb_reg <= mula_reg[48:16] * dt_eff;
            end
            OP_PRED:
            begin
                rem_reg  <= '0;
                dvd_reg  <= {r_noise, 16'b0};
                dvs_reg  <= {33'b0, conf_reg};
                quot_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= ge ? (trial - {1'b0, dvs_reg}) : trial;
                dvd_reg  <= {dvd_reg[31:0], 1'b0};
                quot_reg <= {quot_reg[31:0], ge};
            end
            OP_GINIT:
            begin
                rem_reg   <= {3'b0, p00_reg, 16'b0};
                dvd_reg   <= '0;
                dvs_reg   <= den;
                quot_reg  <= '0;
                innov_reg <= innov_sat;
            end
            OP_MUL3:
            begin
                kprod_reg <= $signed({1'b0, quot_reg[15:0]}) * innov_reg;
                vprod_reg <= p00_reg * (ONE_Q16 - {1'b0, quot_reg[15:0]});
            end
            OP_UPD:
            begin
                rad_reg  <= {vprod_reg[47:16], 16'b0};
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                srem_reg <= sge ? 26'(strial - stest) : strial[25:0];
                root_reg <= {root_reg[22:0], sge};
                rad_reg  <= {rad_reg[45:0], 2'b00};
            end
            OP_OUT:
            begin
                fa_reg <= est_reg;
                ac_reg <= aconf;
                k_reg  <= {1'b0, quot_reg[15:0]};
                in_reg <= innov_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign est_altitude   = fa_reg;
    assign est_confidence = ac_reg;
    assign gain           = k_reg;
    assign innovation     = in_reg;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import skf_pkg::*;

    // Result fields of one filter update, as the block should present them
    typedef struct {
        logic signed [31:0] altitude;
        logic        [16:0] confidence;
        logic        [16:0] gain;
        logic signed [31:0] innovation;
    } estimate_t;

    // One row of the directed stimulus; innovation is typed in only where obvious
    typedef struct {
        logic signed [31:0] altitude;
        logic        [16:0] confidence;
        bit                 has_innov;
        logic signed [31:0] innov;
    } meas_row_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_PHASES  = 10;
    localparam int ITEMS_PER_PHASE = 145;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    skf_in_if  meas_if ();
    skf_out_if est_if ();

    scalar_altitude_kalman_filter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas_in (meas_if),
        .est_out (est_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the filter: its configuration and its state
    logic        [16:0] shadow_q;
    logic        [16:0] shadow_r;
    logic        [16:0] shadow_dt;
    logic signed [31:0] shadow_est;
    logic        [31:0] shadow_p00;
    logic        [31:0] shadow_p11;

    estimate_t pending_estimates[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        quiet_phase;   // when set, neither side idles

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Integer square root, bit by bit, floor of the true root
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root   = 64'd0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v    = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic longint sat_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Advance the shadow filter by one measurement and return what it should output
    function automatic estimate_t kalman_step(input logic signed [31:0] meas,
                                              input logic [16:0] conf);
        estimate_t   res;
        logic [63:0] dtv;
        logic [63:0] spread;
        logic [63:0] p00;
        logic [63:0] p11;
        logic [63:0] conf_eff;
        logic [63:0] r_eff;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] k;
        logic [63:0] root;
        longint      innov;
        longint      prod;
        longint      est_next;

        // predict: widen the altitude variance by the velocity variance over dt
        dtv    = (shadow_dt < DT_FLOOR) ? 64'(DT_FLOOR) : 64'(shadow_dt);
        spread = (64'(shadow_p11) * dtv) >> 16;
        spread = (spread * dtv) >> 16;
        p00 = 64'(shadow_p00) + spread + 64'(shadow_q);
        p11 = 64'(shadow_p11) + 64'(shadow_q);
        if (p00 > 64'hFFFF_FFFF) p00 = 64'hFFFF_FFFF;
        if (p11 > 64'hFFFF_FFFF) p11 = 64'hFFFF_FFFF;
        if (p00 < VAR_FLOOR) p00 = 64'(VAR_FLOOR);
        if (p11 < VAR_FLOOR) p11 = 64'(VAR_FLOOR);
        shadow_p11 = p11[31:0];

        // low confidence inflates the measurement noise
        conf_eff = (conf < CONF_FLOOR) ? 64'(CONF_FLOOR) : 64'(conf);
        r_eff    = (64'(shadow_r) << 16) / conf_eff;

        // gain: sixteen quotient bits of P00 / (P00 + r' + eps)
        den = ((p00 + r_eff) << 16) + 64'(EPS_Q32);
        rem = p00 << 16;
        k   = 64'd0;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            k   = k << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                k[0] = 1'b1;
            end
        end

        // correct the estimate, rounding the step half up
        innov    = sat_s32(longint'(meas) - longint'(shadow_est));
        prod     = longint'(k) * innov;
        est_next = sat_s32(longint'(shadow_est) + ((prod + 64'sd32768) >>> 16));
        shadow_est = est_next[31:0];

        p00        = (p00 * (64'd65536 - k)) >> 16;
        shadow_p00 = p00[31:0];
        root       = int_sqrt(p00 << 16);

        res.altitude   = est_next[31:0];
        res.confidence = (root >= 64'd65536) ? 17'd0 : 17'(64'd65536 - root);
        res.gain       = k[16:0];
        res.innovation = innov[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Register write over the configuration port: setup, then access
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // unknown offsets leave the register file alone
        case (addr)
            {REG_Q, 2'b00}:  shadow_q  = data[16:0];
            {REG_R, 2'b00}:  shadow_r  = data[16:0];
            {REG_DT, 2'b00}: shadow_dt = data[16:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [16:0] q, input logic [16:0] r,
                             input logic [16:0] dt);
        // junk in the upper bits must be dropped by the register
        write_reg({REG_Q, 2'b00}, {$urandom_range(0, 1) ? $urandom() : 32'd0} & 32'hFFFE_0000
                  | 32'(q));
        write_reg({REG_R, 2'b00}, 32'(r));
        write_reg({REG_DT, 2'b00}, 32'(dt));
        if ($urandom_range(0, 2) == 0)
            write_reg(4'd12, $urandom());
    endtask

    // Hold until everything in flight has come back, then let the block settle
    task automatic drain();
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Present one measurement and wait for its transfer; valid is left high
    task automatic send_measurement(input logic signed [31:0] alt, input logic [16:0] conf);
        int        gap;
        int        pick;
        estimate_t pred;
        pick = $urandom_range(0, 99);
        if (quiet_phase || pick < 50)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            meas_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_if.valid               <= 1'b1;
        meas_if.measured_altitude   <= alt;
        meas_if.measured_confidence <= conf;
        do
            @(posedge clk);
        while (!meas_if.ready);
        pred = kalman_step(alt, conf);
        pending_estimates = {pending_estimates, pred};
    endtask

    // Result side: random back-pressure, check each transfer against the oldest prediction
    always @(posedge clk)
    begin
        static int hold_left = 0;
        int        pick;
        estimate_t want;
        if (hold_left > 0)
            hold_left--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (quiet_phase || pick < 60)
            begin
                est_if.ready <= 1'b1;
                hold_left = $urandom_range(0, 5);
            end
            else if (pick < 92)
            begin
                est_if.ready <= 1'b0;
                hold_left = $urandom_range(1, 3);
            end
            else
            begin
                est_if.ready <= 1'b0;
                hold_left = $urandom_range(10, 40);
            end
        end
        if (rst_n && est_if.valid && est_if.ready)
        begin
            if (pending_estimates.size() == 0)
                report_mismatch("unexpected result", est_if.est_altitude, 32'd0);
            else
            begin
                want = pending_estimates[0];
                pending_estimates.delete(0);
                if (est_if.est_altitude !== want.altitude)
                    report_mismatch("est_altitude", est_if.est_altitude,
                                    want.altitude);
                if (est_if.est_confidence !== want.confidence)
                    report_mismatch("est_confidence", 32'(est_if.est_confidence),
                                    32'(want.confidence));
                if (est_if.gain !== want.gain)
                    report_mismatch("gain", 32'(est_if.gain), 32'(want.gain));
                if (est_if.innovation !== want.innovation)
                    report_mismatch("innovation", est_if.innovation, want.innovation);
            end
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run
    always @(posedge clk)
    begin
        if ((meas_if.valid && meas_if.ready) || (est_if.valid && est_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scalar_altitude_kalman_filter regression: fail");
            $finish;
        end
    end

    initial
    begin
        meas_row_t          directed_rows[12];
        meas_row_t          row;
        logic signed [31:0] track;
        logic signed [31:0] alt;
        logic        [16:0] conf;
        int                 pick;

        mismatch_count = 0;
        idle_cycles    = 0;
        quiet_phase    = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 4'd0;
        pwdata         = 32'd0;
        meas_if.valid               = 1'b0;
        meas_if.measured_altitude   = 32'sd0;
        meas_if.measured_confidence = 17'd0;
        est_if.ready                = 1'b0;

        shadow_q   = Q_RESET;
        shadow_r   = R_RESET;
        shadow_dt  = DT_RESET;
        shadow_est = 32'sd0;
        shadow_p00 = P00_RESET;
        shadow_p11 = P11_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings first, field extremes and the confidence floor.
        // Straight after reset the estimate is zero, so a zero reading has zero innovation.
        directed_rows[0]  = '{32'sd0, 17'd65536, 1'b1, 32'sd0};
        directed_rows[1]  = '{32'sh7FFF_FFFF, 17'h1FFFF, 1'b0, 32'sd0};
        directed_rows[2]  = '{32'sh8000_0000, 17'd0, 1'b0, 32'sd0};
        directed_rows[3]  = '{32'sh8000_0000, 17'd6553, 1'b0, 32'sd0};
        directed_rows[4]  = '{32'sh7FFF_FFFF, 17'd6554, 1'b0, 32'sd0};
        directed_rows[5]  = '{32'sh7FFF_FFFF, 17'd65536, 1'b0, 32'sd0};
        directed_rows[6]  = '{32'sd6553600, 17'd1, 1'b0, 32'sd0};
        directed_rows[7]  = '{32'sd6553600, 17'd65535, 1'b0, 32'sd0};
        directed_rows[8]  = '{-32'sd1, 17'd32768, 1'b0, 32'sd0};
        directed_rows[9]  = '{32'sd1, 17'd6555, 1'b0, 32'sd0};
        directed_rows[10] = '{32'sh5555_5555, 17'h0AAAA, 1'b0, 32'sd0};
        directed_rows[11] = '{32'shAAAA_AAAA, 17'h15555, 1'b0, 32'sd0};

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_measurement(row.altitude, row.confidence);
            if (row.has_innov && pending_estimates[$].innovation !== row.innov)
                report_mismatch("directed innovation", pending_estimates[$].innovation,
                                row.innov);
        end
        meas_if.valid <= 1'b0;
        drain();

        // Directed: configuration extremes, including a time step below its floor
        configure(17'd0, 17'd0, 17'd0);
        send_measurement(32'sd655360, 17'd65536);
        send_measurement(-32'sd655360, 17'd0);
        send_measurement(32'sh7FFF_FFFF, 17'h1FFFF);
        meas_if.valid <= 1'b0;
        drain();
        configure(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        for (int i = 0; i < 6; i++)
            send_measurement(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF, i[1] ? 17'd0 : 17'h1FFFF);
        meas_if.valid <= 1'b0;
        drain();
        configure(17'd1, 17'd65536, 17'd66);
        send_measurement(32'sd100, 17'd65536);
        send_measurement(32'sd200, 17'd6554);
        meas_if.valid <= 1'b0;
        drain();

        // Random phases: mostly a plausible altitude track with sensor noise,
        // some outliers, and a share of arbitrary readings
        track = 32'sd0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: configure(Q_RESET, R_RESET, DT_RESET);
                1: configure(17'd65536, 17'd65536, 17'd65536);
                2: configure(17'd0, 17'd1, 17'd65);
                3: configure(17'h1FFFF, 17'd0, 17'd66);
                default: configure(17'($urandom_range(0, 65536)),
                                   17'($urandom_range(0, 65536)),
                                   ($urandom_range(0, 3) == 0)
                                       ? 17'($urandom_range(0, 17'h1FFFF))
                                       : 17'($urandom_range(66, 65536)));
            endcase
            quiet_phase = (ph % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    track = track + $signed($urandom_range(0, 131072)) - 32'sd65536;
                    alt   = track + $signed($urandom_range(0, 655360)) - 32'sd327680;
                end
                else if (pick < 85)
                    alt = track + $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
                else if (pick < 97)
                    alt = $urandom();
                else
                    alt = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                if ($urandom_range(0, 49) == 0)
                    track = $urandom_range(0, 32'h00FF_FFFF) - 32'sh0080_0000;
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    conf = 17'($urandom_range(6554, 65536));
                else if (pick < 90)
                    conf = 17'($urandom_range(0, 6553));
                else
                    conf = 17'($urandom_range(0, 17'h1FFFF));
                send_measurement(alt, conf);
            end
            meas_if.valid <= 1'b0;
            drain();
        end

        quiet_phase = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_estimates.size() == 0)
            $display("scalar_altitude_kalman_filter regression: pass");
        else
            $display("scalar_altitude_kalman_filter regression: fail");
        $finish;
    end

endmodule
